// ----- rtl/ippb_pkg.sv -----
// Shared types, constants and the CORDIC arc table for the interferometric phase core.
package ippb_pkg;

  localparam int unsigned MAX_RANGE_BINS_DEF = 4096;
  localparam int unsigned MAX_PULSES_DEF     = 4096;
  localparam int unsigned SAMPLE_BITS_DEF    = 16;
  localparam int unsigned PHASE_BITS_DEF     = 16;

  localparam int unsigned ACC_BITS     = 46;
  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned ANGLE_BITS   = 32;
  localparam int unsigned BIN_BITS     = 13;
  localparam int unsigned LEN_BITS     = 13;
  localparam int unsigned WIN_BITS     = 12;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RANGE_LENGTH,
    CFG_PULSE_COUNT,
    CFG_RANGE_FIRST,
    CFG_RANGE_LAST,
    CFG_AZIMUTH_FIRST,
    CFG_AZIMUTH_LAST
  } cfg_idx_e;

  typedef struct packed {
    logic [LEN_BITS-1:0] range_length;
    logic [LEN_BITS-1:0] pulse_count;
    logic [WIN_BITS-1:0] range_first;
    logic [WIN_BITS-1:0] range_last;
    logic [WIN_BITS-1:0] azimuth_first;
    logic [WIN_BITS-1:0] azimuth_last;
  } cfg_t;

  // Result tag that rides along with a sum down the CORDIC pipe
  typedef struct packed {
    logic [BIN_BITS-1:0] bin;
    logic                last;
  } meta_t;

  // atan(2^-i) with a full turn equal to 2^32
  function automatic logic [ANGLE_BITS-1:0] arc_angle(input int unsigned i);
    logic [ANGLE_BITS-1:0] a;
    case (i)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      24:      a = 32'h0000_0029;
      25:      a = 32'h0000_0014;
      26:      a = 32'h0000_000A;
      27:      a = 32'h0000_0005;
      28:      a = 32'h0000_0003;
      29:      a = 32'h0000_0001;
      30:      a = 32'h0000_0001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/ippb_accum.sv -----
// Raster position tracking, conjugate product and per-bin accumulator memory with forwarding.
module ippb_accum
  import ippb_pkg::*;
#(
  parameter int unsigned MAX_RANGE_BINS = MAX_RANGE_BINS_DEF,
  parameter int unsigned MAX_PULSES     = MAX_PULSES_DEF,
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       accept_i,
  input  logic signed [SAMPLE_BITS-1:0] first_re_i,
  input  logic signed [SAMPLE_BITS-1:0] first_im_i,
  input  logic signed [SAMPLE_BITS-1:0] second_re_i,
  input  logic signed [SAMPLE_BITS-1:0] second_im_i,
  input  cfg_t                       cfg_i,
  output logic                       sum_valid_o,
  output logic signed [ACC_BITS-1:0] sum_re_o,
  output logic signed [ACC_BITS-1:0] sum_im_o,
  output meta_t                      meta_o
);

  localparam int unsigned CW   = (MAX_RANGE_BINS > 1) ? $clog2(MAX_RANGE_BINS) : 1;
  localparam int unsigned RW   = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
  localparam int unsigned MW0  = (CW > RW) ? CW : RW;
  localparam int unsigned MW1  = (MW0 > LEN_BITS) ? MW0 : LEN_BITS;
  localparam int unsigned CMPW = MW1 + 1;
  localparam int unsigned MW   = 2 * SAMPLE_BITS;
  localparam int unsigned PW   = MW + 1;

  // position
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [CMPW-1:0] len_m1, pls_m1, rf, rl, af, al, col_e, row_e;
  logic            in_win;

  always_comb begin
    if (cfg_i.range_length == '0) begin
      len_m1 = '0;
    end else if (CMPW'(cfg_i.range_length) > CMPW'(MAX_RANGE_BINS)) begin
      len_m1 = CMPW'(MAX_RANGE_BINS - 1);
    end else begin
      len_m1 = CMPW'(cfg_i.range_length) - 1'b1;
    end
    if (cfg_i.pulse_count == '0) begin
      pls_m1 = '0;
    end else if (CMPW'(cfg_i.pulse_count) > CMPW'(MAX_PULSES)) begin
      pls_m1 = CMPW'(MAX_PULSES - 1);
    end else begin
      pls_m1 = CMPW'(cfg_i.pulse_count) - 1'b1;
    end
    rf = (CMPW'(cfg_i.range_first) > len_m1) ? len_m1 : CMPW'(cfg_i.range_first);
    rl = (CMPW'(cfg_i.range_last) > len_m1) ? len_m1 : CMPW'(cfg_i.range_last);
    af = (CMPW'(cfg_i.azimuth_first) > pls_m1) ? pls_m1 : CMPW'(cfg_i.azimuth_first);
    al = (CMPW'(cfg_i.azimuth_last) > pls_m1) ? pls_m1 : CMPW'(cfg_i.azimuth_last);
    col_e  = CMPW'(col_q);
    row_e  = CMPW'(row_q);
    in_win = (col_e >= rf) && (col_e <= rl) && (row_e >= af) && (row_e <= al);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_e >= len_m1) begin
        col_d = '0;
        if (row_e >= pls_m1) begin
          row_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // first * conj(second)
  logic signed [MW-1:0] m_rr, m_ii, m_ir, m_ri;
  logic signed [PW-1:0] prod_re, prod_im;

  assign m_rr    = first_re_i * second_re_i;
  assign m_ii    = first_im_i * second_im_i;
  assign m_ir    = first_im_i * second_re_i;
  assign m_ri    = first_re_i * second_im_i;
  assign prod_re = {m_rr[MW-1], m_rr} + {m_ii[MW-1], m_ii};
  assign prod_im = {m_ir[MW-1], m_ir} - {m_ri[MW-1], m_ri};

  // stage 1: product registered, memory word arriving
  logic                 s1_valid_q;
  logic                 s1_load_q, s1_emit_q, s1_last_q;
  logic [CW-1:0]        s1_col_q;
  logic signed [PW-1:0] s1_re_q, s1_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= accept_i && in_win;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_load_q <= (row_e == af);
      s1_emit_q <= (row_e == al);
      s1_last_q <= (col_e == rl);
      s1_col_q  <= col_q;
      s1_re_q   <= prod_re;
      s1_im_q   <= prod_im;
    end
  end

  // accumulator memory, {imag, real} per bin
  logic [2*ACC_BITS-1:0] mem_q [MAX_RANGE_BINS];
  logic [2*ACC_BITS-1:0] rd_q;
  logic [2*ACC_BITS-1:0] wr_data;
  logic                  wr_en;
  logic                  fwd_q;
  logic [2*ACC_BITS-1:0] fwd_data_q;

  assign wr_en = en_i && s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q <= mem_q[col_q];
    end
    if (wr_en) begin
      mem_q[s1_col_q] <= wr_data;
    end
  end

  // read and write of the same bin on one edge: memory returns the old word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (en_i) begin
      fwd_q <= accept_i && s1_valid_q && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fwd_data_q <= wr_data;
    end
  end

  logic [2*ACC_BITS-1:0] old_word;
  logic signed [ACC_BITS-1:0] old_re, old_im, add_re, add_im, sum_re, sum_im;

  always_comb begin
    old_word = fwd_q ? fwd_data_q : rd_q;
    old_re   = old_word[ACC_BITS-1:0];
    old_im   = old_word[2*ACC_BITS-1:ACC_BITS];
    add_re   = ACC_BITS'(s1_re_q);
    add_im   = ACC_BITS'(s1_im_q);
    sum_re   = s1_load_q ? add_re : old_re + add_re;
    sum_im   = s1_load_q ? add_im : old_im + add_im;
    wr_data  = {sum_im, sum_re};
  end

  // stage 2: finished sums of the last window row
  logic [CW:0] col_p1;
  assign col_p1 = {1'b0, s1_col_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_o <= 1'b0;
    end else if (en_i) begin
      sum_valid_o <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_re_o    <= sum_re;
      sum_im_o    <= sum_im;
      meta_o.bin  <= BIN_BITS'(col_p1);
      meta_o.last <= s1_last_q;
    end
  end

endmodule

// ----- rtl/ippb_cordic.sv -----
// Pipelined vectoring CORDIC: angle of an accumulated sum, one stage per iteration.
module ippb_cordic
  import ippb_pkg::*;
#(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [ACC_BITS-1:0] x_i,
  input  logic signed [ACC_BITS-1:0] y_i,
  input  meta_t                      meta_i,
  output logic                       valid_o,
  output logic [PHASE_BITS-1:0]      phase_o,
  output meta_t                      meta_o
);

  // headroom for the negation of the most negative sum and the CORDIC gain
  localparam int unsigned XW = ACC_BITS + 3;
  localparam logic [ANGLE_BITS-1:0] ANGLE_PI = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic                    v_q    [CORDIC_STEPS+1];
  logic                    sp_q   [CORDIC_STEPS+1];
  logic signed [XW-1:0]    x_q    [CORDIC_STEPS+1];
  logic signed [XW-1:0]    y_q    [CORDIC_STEPS+1];
  logic [ANGLE_BITS-1:0]   z_q    [CORDIC_STEPS+1];
  meta_t                   meta_q [CORDIC_STEPS+1];

  logic signed [XW-1:0] x_ext, y_ext;
  assign x_ext = XW'(x_i);
  assign y_ext = XW'(y_i);

  // pre-rotation into the right half plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta_i;
      // on the real axis the seed angle is already the answer
      sp_q[0]   <= (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_ext;
        y_q[0] <= -y_ext;
        z_q[0] <= ANGLE_PI;
      end else begin
        x_q[0] <= x_ext;
        y_q[0] <= y_ext;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        meta_q[i+1] <= meta_q[i];
        sp_q[i+1]   <= sp_q[i];
        if (!y_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= sp_q[i] ? z_q[i] : z_q[i] + arc_angle(i);
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= sp_q[i] ? z_q[i] : z_q[i] - arc_angle(i);
        end
      end
    end
  end

  // round to the output scale
  logic [ANGLE_BITS-1:0] z_rnd;
  assign z_rnd   = z_q[CORDIC_STEPS] + (ANGLE_BITS'(1) << (ANGLE_BITS - 1 - PHASE_BITS));
  assign phase_o = z_rnd[ANGLE_BITS-1 -: PHASE_BITS];
  assign valid_o = v_q[CORDIC_STEPS];
  assign meta_o  = meta_q[CORDIC_STEPS];

endmodule

// ----- rtl/interferometric_phase_per_range_bin_core.sv -----
// Top level: configuration registers, stream ports, stall control and output register.
//
// Streams a raster of paired complex samples (row-major, azimuth rows of range columns),
// sums first * conj(second) per range bin over the azimuth window and, on the last window
// row, returns the phase of each bin's sum (2^(PHASE_BITS-1) = pi) with its 1-based bin
// number; tlast marks the last bin of the range window. One transaction is accepted per
// clock while the input is not stalled; the path of a result runs through the
// read-modify-write of the accumulator memory (MAX_RANGE_BINS words of 2 x 46 bits, one
// read and one write port, with forwarding so that a one-column raster still runs every
// cycle), the pre-rotation and 32 stages of the CORDIC pipe and the output register. The
// input stalls only while a result sits unread in the output register and the next one
// reaches the end of the pipe. The accumulators are not cleared: each bin is loaded by the
// first row of its azimuth window, so every emitting row must be preceded by that row.
// Configuration must be written only while the block is idle; the block does not enforce
// this. The raster position is never reset by a write.
module interferometric_phase_per_range_bin_core
  import ippb_pkg::*;
#(
  parameter int unsigned MAX_RANGE_BINS = MAX_RANGE_BINS_DEF,
  parameter int unsigned MAX_PULSES     = MAX_PULSES_DEF,
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int unsigned PHASE_BITS     = PHASE_BITS_DEF,
  localparam int unsigned IN_W  = ((4 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((PHASE_BITS + BIN_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [LEN_BITS-1:0]     cfg_wdata_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_W-1:0]         s_axis_tdata,  // first_re, first_im, second_re, second_im
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_W-1:0]        m_axis_tdata,  // phase, bin_number
  output logic                    m_axis_tlast   // window_done
);

  // configuration
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_length  <= LEN_BITS'(4096);
      cfg_q.pulse_count   <= LEN_BITS'(4096);
      cfg_q.range_first   <= '0;
      cfg_q.range_last    <= WIN_BITS'(4095);
      cfg_q.azimuth_first <= '0;
      cfg_q.azimuth_last  <= WIN_BITS'(4095);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RANGE_LENGTH:  cfg_q.range_length  <= cfg_wdata_i;
        CFG_PULSE_COUNT:   cfg_q.pulse_count   <= cfg_wdata_i;
        CFG_RANGE_FIRST:   cfg_q.range_first   <= cfg_wdata_i[WIN_BITS-1:0];
        CFG_RANGE_LAST:    cfg_q.range_last    <= cfg_wdata_i[WIN_BITS-1:0];
        CFG_AZIMUTH_FIRST: cfg_q.azimuth_first <= cfg_wdata_i[WIN_BITS-1:0];
        CFG_AZIMUTH_LAST:  cfg_q.azimuth_last  <= cfg_wdata_i[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: hold everything only when a new result meets a full output register
  logic cord_valid;
  logic en;
  logic accept;
  logic out_valid_q;

  assign en            = !(cord_valid && out_valid_q && !m_axis_tready);
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  logic signed [SAMPLE_BITS-1:0] first_re, first_im, second_re, second_im;
  assign first_re  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign first_im  = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign second_re = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign second_im = s_axis_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];

  logic                       sum_valid;
  logic signed [ACC_BITS-1:0] sum_re, sum_im;
  meta_t                      sum_meta;

  ippb_accum #(
    .MAX_RANGE_BINS (MAX_RANGE_BINS),
    .MAX_PULSES     (MAX_PULSES),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .accept_i    (accept),
    .first_re_i  (first_re),
    .first_im_i  (first_im),
    .second_re_i (second_re),
    .second_im_i (second_im),
    .cfg_i       (cfg_q),
    .sum_valid_o (sum_valid),
    .sum_re_o    (sum_re),
    .sum_im_o    (sum_im),
    .meta_o      (sum_meta)
  );

  logic [PHASE_BITS-1:0] cord_phase;
  meta_t                 cord_meta;

  ippb_cordic #(
    .PHASE_BITS (PHASE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sum_valid),
    .x_i     (sum_re),
    .y_i     (sum_im),
    .meta_i  (sum_meta),
    .valid_o (cord_valid),
    .phase_o (cord_phase),
    .meta_o  (cord_meta)
  );

  // output register
  logic [PHASE_BITS-1:0] out_phase_q;
  meta_t                 out_meta_q;
  logic                  out_valid_d;
  logic                  out_load;

  assign out_load = en && cord_valid;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_phase_q <= cord_phase;
      out_meta_q  <= cord_meta;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_meta_q.bin, out_phase_q});
  assign m_axis_tlast  = out_meta_q.last;

endmodule

// ----- sim/interferometric_phase_per_range_bin_core_tb.sv -----
// Self-checking testbench for the interferometric phase core: raster stimulus, phase prediction.
`timescale 1ns / 100ps

module interferometric_phase_per_range_bin_core_tb;
  import ippb_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = 3'd7;
  localparam int unsigned BIN_LIMIT   = 4096;
  localparam int unsigned ROW_LIMIT   = 4096;
  localparam int unsigned DRAIN_CYC   = 64;
  localparam int unsigned RANDOM_GOAL = 1150;
  localparam int unsigned LONG_ROW    = 300;
  localparam int unsigned TALL_FRAME  = 200;

  // one sample pair; packed so that first_re lands in the low bits of tdata
  typedef struct packed {
    logic [15:0] b_im;
    logic [15:0] b_re;
    logic [15:0] a_im;
    logic [15:0] a_re;
  } sample_t;

  typedef struct packed {
    logic [15:0]         phase;
    logic [BIN_BITS-1:0] bin;
    logic                done;
  } bin_phase_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i     = '0;
  logic [LEN_BITS-1:0]     cfg_wdata_i   = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [63:0]             s_axis_tdata  = '0;  // first_re, first_im, second_re, second_im
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [31:0]             m_axis_tdata;        // phase, bin_number
  logic                    m_axis_tlast;        // window_done

  interferometric_phase_per_range_bin_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("interferometric_phase_per_range_bin_core_tb NOT OK");
    $finish;
  end

  sample_t    pending_samples[$];
  bin_phase_t phase_expect[$];
  bit         steady   = 1'b0;
  bit         sent_ok  = 1'b0;
  int unsigned n_fail    = 0;
  int unsigned n_samples = 0;
  int unsigned n_summed  = 0;
  int unsigned n_phases  = 0;
  int unsigned n_setups  = 0;

  // shadow registers and raster position as the block sees them
  logic [LEN_BITS-1:0] set_len     = 13'd4096;
  logic [LEN_BITS-1:0] set_pulses  = 13'd4096;
  logic [WIN_BITS-1:0] set_rfirst  = 12'd0;
  logic [WIN_BITS-1:0] set_rlast   = 12'd4095;
  logic [WIN_BITS-1:0] set_azfirst = 12'd0;
  logic [WIN_BITS-1:0] set_azlast  = 12'd4095;
  int unsigned raster_col = 0;
  int unsigned raster_row = 0;
  logic signed [ACC_BITS-1:0] acc_re [BIN_LIMIT];
  logic signed [ACC_BITS-1:0] acc_im [BIN_LIMIT];

  function automatic logic [31:0] arc_step(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h2000_0000;  1:  a = 32'h12E4_051E;  2:  a = 32'h09FB_385B;
      3:  a = 32'h0511_11D4;  4:  a = 32'h028B_0D43;  5:  a = 32'h0145_D7E1;
      6:  a = 32'h00A2_F61E;  7:  a = 32'h0051_7C55;  8:  a = 32'h0028_BE53;
      9:  a = 32'h0014_5F2F;  10: a = 32'h000A_2F98;  11: a = 32'h0005_17CC;
      12: a = 32'h0002_8BE6;  13: a = 32'h0001_45F3;  14: a = 32'h0000_A2FA;
      15: a = 32'h0000_517D;  16: a = 32'h0000_28BE;  17: a = 32'h0000_145F;
      18: a = 32'h0000_0A30;  19: a = 32'h0000_0518;  20: a = 32'h0000_028C;
      21: a = 32'h0000_0146;  22: a = 32'h0000_00A3;  23: a = 32'h0000_0051;
      24: a = 32'h0000_0029;  25: a = 32'h0000_0014;  26: a = 32'h0000_000A;
      27: a = 32'h0000_0005;  28: a = 32'h0000_0003;  29: a = 32'h0000_0001;
      30: a = 32'h0000_0001;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // vectoring CORDIC, angle in 2^32 per turn, rounded to 16 bits
  function automatic logic [15:0] cordic_phase(input longint xin, input longint yin);
    longint      x, y, xs, ys;
    logic [31:0] z;
    int unsigned i;
    x = xin;
    y = yin;
    z = 32'h0;
    if (y == 0) begin
      z = (x < 0) ? 32'h8000_0000 : 32'h0;
    end else begin
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (i = 0; i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arc_step(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arc_step(i);
        end
      end
    end
    z = z + 32'h0000_8000;
    return z[31:16];
  endfunction

  function automatic int unsigned clamp_size(input logic [LEN_BITS-1:0] v,
                                             input int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : int'(v);
  endfunction

  function automatic int unsigned clamp_edge(input logic [WIN_BITS-1:0] v,
                                             input int unsigned size);
    return (v > size - 1) ? size - 1 : int'(v);
  endfunction

  task automatic predict_sample(input sample_t s);
    int unsigned le, pe, rf, rl, af, al;
    longint      pr, pim;
    logic signed [ACC_BITS-1:0] nre, nim;
    bin_phase_t  r;
    le = clamp_size(set_len, BIN_LIMIT);
    pe = clamp_size(set_pulses, ROW_LIMIT);
    rf = clamp_edge(set_rfirst, le);
    rl = clamp_edge(set_rlast, le);
    af = clamp_edge(set_azfirst, pe);
    al = clamp_edge(set_azlast, pe);
    if (raster_col >= rf && raster_col <= rl && raster_row >= af && raster_row <= al) begin
      n_summed++;
      pr  = longint'($signed(s.a_re)) * longint'($signed(s.b_re)) +
            longint'($signed(s.a_im)) * longint'($signed(s.b_im));
      pim = longint'($signed(s.a_im)) * longint'($signed(s.b_re)) -
            longint'($signed(s.a_re)) * longint'($signed(s.b_im));
      nre = pr[ACC_BITS-1:0];
      nim = pim[ACC_BITS-1:0];
      // first window row loads, later rows add
      if (raster_row != af) begin
        nre = nre + acc_re[raster_col];
        nim = nim + acc_im[raster_col];
      end
      acc_re[raster_col] = nre;
      acc_im[raster_col] = nim;
      if (raster_row == al) begin
        r.phase = cordic_phase(longint'(nre), longint'(nim));
        r.bin   = BIN_BITS'(raster_col + 1);
        r.done  = (raster_col == rl);
        phase_expect.insert(phase_expect.size(), r);
      end
    end
    if (raster_col + 1 >= le) begin
      raster_col = 0;
      raster_row = (raster_row + 1 >= pe) ? 0 : raster_row + 1;
    end else begin
      raster_col++;
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || sent_ok) begin
      if (rst_ni && pending_samples.size() != 0 &&
          (steady || $urandom_range(0, 99) >= 36)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_samples[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    sent_ok = 1'b0;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_sample(pending_samples.pop_front());
      n_samples++;
      sent_ok = 1'b1;
    end
  end

  // receiver and checker
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk_i) begin
    bin_phase_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (phase_expect.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: unexpected result phase %0d bin %0d done %0b", $realtime,
                   $signed(m_axis_tdata[15:0]), m_axis_tdata[28:16], m_axis_tlast);
      end else begin
        want = phase_expect.pop_front();
        n_phases++;
        if (m_axis_tdata[15:0] !== want.phase || m_axis_tdata[28:16] !== want.bin ||
            m_axis_tlast !== want.done) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: phase %0d exp %0d, bin %0d exp %0d, done %0b exp %0b",
                     $realtime, $signed(m_axis_tdata[15:0]), $signed(want.phase),
                     m_axis_tdata[28:16], want.bin, m_axis_tlast, want.done);
        end
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [LEN_BITS-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_RANGE_LENGTH:  set_len     = val;
      CFG_PULSE_COUNT:   set_pulses  = val;
      CFG_RANGE_FIRST:   set_rfirst  = val[WIN_BITS-1:0];
      CFG_RANGE_LAST:    set_rlast   = val[WIN_BITS-1:0];
      CFG_AZIMUTH_FIRST: set_azfirst = val[WIN_BITS-1:0];
      CFG_AZIMUTH_LAST:  set_azlast  = val[WIN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [LEN_BITS-1:0] lenr, pulr, rf, rl, af, al,
                             input bit poke_spare);
    if (poke_spare)
      cfg_write($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                LEN_BITS'($urandom));
    cfg_write(CFG_RANGE_LENGTH, lenr);
    cfg_write(CFG_PULSE_COUNT, pulr);
    cfg_write(CFG_RANGE_FIRST, rf);
    cfg_write(CFG_RANGE_LAST, rl);
    cfg_write(CFG_AZIMUTH_FIRST, af);
    cfg_write(CFG_AZIMUTH_LAST, al);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_setups++;
  endtask

  // hold off until every transaction is in and every result is out, then let the pipe drain
  task automatic settle();
    while (pending_samples.size() != 0 || phase_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic queue_sample(input sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endtask

  function automatic sample_t mk(input int ar, ai, br, bi);
    sample_t s;
    s.a_re = 16'(ar);
    s.a_im = 16'(ai);
    s.b_re = 16'(br);
    s.b_im = 16'(bi);
    return s;
  endfunction

  function automatic logic [15:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if (r < 30) return 16'($urandom_range(0, 16) - 8);
    return 16'($urandom);
  endfunction

  function automatic sample_t rand_sample();
    sample_t     s;
    int unsigned r;
    r = $urandom_range(0, 99);
    s = {rand_word(), rand_word(), rand_word(), rand_word()};
    if (r < 8) begin
      // same pair on both channels: product on the positive real axis
      s.b_re = s.a_re;
      s.b_im = s.a_im;
    end else if (r < 12) begin
      s.b_re = -s.a_re;
      s.b_im = -s.a_im;
    end else if (r < 15) begin
      s = '0;
    end
    return s;
  endfunction

  function automatic logic [LEN_BITS-1:0] pick_size(input int unsigned small_top);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 9) return LEN_BITS'($urandom_range(4096, 8191));
    return LEN_BITS'($urandom_range(1, small_top));
  endfunction

  // window edge, sometimes past the clamp or with the unused top bit set
  function automatic logic [LEN_BITS-1:0] pick_edge(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return LEN_BITS'(4095);
    if (r < 10) return LEN_BITS'(13'h1000 | $urandom_range(0, span));
    return LEN_BITS'($urandom_range(0, span));
  endfunction

  initial begin
    int unsigned le, pe, frame, n, base, lspan, pspan;
    logic [LEN_BITS-1:0] lenr, pulr, rf, rl, af, al, tmp;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single window row: every transaction loads and emits; zero, real axis and extremes
    apply_setup(13'd4, 13'd1, 13'd0, 13'd3, 13'd0, 13'd0, 1'b0);
    queue_sample(mk(0, 0, 0, 0));
    queue_sample(mk(1, 0, 1, 0));
    queue_sample(mk(-1, 0, 1, 0));
    queue_sample(mk(0, 1, 1, 0));
    queue_sample(mk(-32768, -32768, -32768, -32768));
    queue_sample(mk(-32768, -32768, 32767, 32767));
    queue_sample(mk(32767, -32768, -32768, 32767));
    queue_sample(mk(32767, 32767, 32767, -32768));
    settle();

    // length 0 acts as one column; window edges clamp; rows 1..2 summed
    apply_setup(13'd0, 13'd3, 13'd4095, 13'd4095, 13'd1, 13'd2, 1'b1);
    repeat (2) begin
      queue_sample(rand_sample());
      queue_sample(mk(-32768, -32768, -32768, 32767));
      queue_sample(mk(32767, 32767, -32768, -32768));
    end
    settle();

    // empty range window
    apply_setup(13'd3, 13'd2, 13'd2, 13'd1, 13'd0, 13'd1, 1'b0);
    repeat (6) queue_sample(rand_sample());
    settle();

    // long raster row, window end past the row end, no idling
    steady = 1'b1;
    apply_setup(LEN_BITS'(LONG_ROW), 13'd1, LEN_BITS'(LONG_ROW - 3), 13'd4095, 13'd0,
                13'd4095, 1'b0);
    repeat (LONG_ROW) queue_sample(rand_sample());
    settle();
    steady = 1'b0;

    // tall frame, one column, sum over every row
    apply_setup(13'd1, LEN_BITS'(TALL_FRAME), 13'd0, 13'd0, 13'd0, 13'd4095, 1'b0);
    repeat (TALL_FRAME)
      queue_sample($urandom_range(0, 1) ? mk(-32768, -32768, -32768, -32768)
                                        : rand_sample());
    settle();

    base = n_samples;
    while (n_samples - base < RANDOM_GOAL) begin
      lenr  = pick_size(12);
      pulr  = pick_size(10);
      le    = clamp_size(lenr, BIN_LIMIT);
      pe    = clamp_size(pulr, ROW_LIMIT);
      lspan = (le > 12) ? 12 : le;
      pspan = (pe > 12) ? 12 : pe;
      rf = pick_edge(lspan);
      rl = pick_edge(lspan);
      af = pick_edge(pspan);
      al = pick_edge(pspan);
      // mostly non-empty windows
      if (rf[WIN_BITS-1:0] > rl[WIN_BITS-1:0] && $urandom_range(0, 99) < 80) begin
        tmp = rf; rf = rl; rl = tmp;
      end
      if (af[WIN_BITS-1:0] > al[WIN_BITS-1:0] && $urandom_range(0, 99) < 80) begin
        tmp = af; af = al; al = tmp;
      end
      apply_setup(lenr, pulr, rf, rl, af, al, $urandom_range(0, 99) < 15);
      frame = le * pe;
      if (frame <= 200) begin
        n = frame * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, frame);
      end else begin
        n = $urandom_range(20, 200);
      end
      if (n > 400) n = 400;
      steady = ($urandom_range(0, 9) == 0);
      repeat (n) queue_sample(rand_sample());
      settle();
      steady = 1'b0;
      // broken frame: a one-by-one raster puts the position back at the origin
      if (raster_col != 0 || raster_row != 0) begin
        apply_setup(13'd1, 13'd1, rf, rl, af, al, 1'b0);
        queue_sample(rand_sample());
        settle();
      end
    end

    $display("Run: %0d sample pairs sent, %0d summed into windows, %0d register setups",
             n_samples, n_summed, n_setups);
    $display("Run: %0d bin phases compared, %0d failures", n_phases, n_fail);
    if (n_fail == 0)
      $display("interferometric_phase_per_range_bin_core_tb OK");
    else
      $display("interferometric_phase_per_range_bin_core_tb NOT OK");
    $finish;
  end

endmodule
